### sv/escaped_frame_receiver_crc16_defines.svh
// assertion macros used by the frame receiver top level
// needs clk_i and rst_ni in the scope of each use
`ifndef ESCAPED_FRAME_RECEIVER_CRC16_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_CRC16_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle, checked outside reset
`define EFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/efr_pkg.sv
// types, constants and the crc-16 byte update for the escaped frame receiver
// no dependencies
package efr_pkg;

  localparam int unsigned FRAME_BYTES = 15;

  localparam logic [7:0] START_CODE  = 8'hFF;
  localparam logic [7:0] ESCAPE_CODE = 8'hFE;

  localparam logic [3:0] LAST_POS   = 4'(FRAME_BYTES - 1);
  localparam logic [3:0] CRC_LO_POS = 4'(FRAME_BYTES - 2);

  localparam logic [7:0] PURGE_THRESHOLD_RST = 8'd60;

  localparam logic KIND_EPOCH = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] byte_index;
    logic       frame_end;
    logic       crc_ok;
    logic       frame_kind;
    logic       purge;
  } efr_result_t;

  // one byte of crc-16, poly 0x1021, msb first
  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ (x >> 4);
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
           ^ {8'h00, x};
  endfunction

endpackage

### sv/efr_frame_core.sv
// unescaping, frame position, crc check and purge counter of the receiver
// depends on efr_pkg
module efr_frame_core import efr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [7:0]  threshold_i,
  output logic        res_valid_o,
  output efr_result_t res_o
);

  logic        esc_q, esc_d;
  logic [3:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q;
  logic        mode_q, mode_d;
  logic [7:0]  count_q, count_d;

  logic        is_ctrl;
  logic        is_last;
  logic        ok;
  logic [8:0]  cnt_inc;
  logic        hit;
  logic        purge;

  assign is_ctrl = !esc_q && (byte_i == ESCAPE_CODE || byte_i == START_CODE);
  assign is_last = (pos_q == LAST_POS);
  assign ok      = ({byte_i, crc_lo_q} == crc_q);
  assign cnt_inc = {1'b0, count_q} + 9'd1;
  assign hit     = (cnt_inc >= {1'b0, threshold_i});
  assign purge   = is_last && mode_q && ok && hit;

  always_comb begin
    esc_d   = esc_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    mode_d  = mode_q;
    count_d = count_q;
    if (esc_q) begin
      esc_d = 1'b0;
    end
    if (is_ctrl) begin
      if (byte_i == ESCAPE_CODE) begin
        esc_d = 1'b1;
      end else begin
        pos_d = '0;
        crc_d = '0;
      end
    end else begin
      if (pos_q < CRC_LO_POS) begin
        crc_d = crc16_update(crc_q, byte_i);
      end
      if (is_last) begin
        pos_d = '0;
        crc_d = '0;
        if (!mode_q) begin
          mode_d = 1'b1;
        end else if (ok) begin
          count_d = hit ? 8'd0 : cnt_inc[7:0];
        end
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= 1'b0;
      pos_q   <= '0;
      crc_q   <= '0;
      mode_q  <= KIND_EPOCH;
      count_q <= '0;
    end else if (step_i) begin
      esc_q   <= esc_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

  // low crc byte needs no reset, always written before the last byte
  always_ff @(posedge clk_i) begin
    if (step_i && !is_ctrl && pos_q == CRC_LO_POS) begin
      crc_lo_q <= byte_i;
    end
  end

  assign res_valid_o       = !is_ctrl;
  assign res_o.data_byte   = byte_i;
  assign res_o.byte_index  = pos_q;
  assign res_o.frame_end   = is_last;
  assign res_o.crc_ok      = is_last && ok;
  assign res_o.frame_kind  = mode_q;
  assign res_o.purge       = purge;

endmodule

### sv/escaped_frame_receiver_crc16.sv
// top level of the byte-stuffed frame receiver with crc-16 check
// depends on efr_pkg, efr_frame_core and escaped_frame_receiver_crc16_defines.svh
//
// usage:
//   input channel: one raw uart byte per word on rx_byte_i (in_valid_i/in_ready_o).
//   0xff restarts a frame and 0xfe escapes the next byte; neither yields a word.
//   output channel: one word per data byte (out_valid_o/out_ready_i) with its index,
//   frame end flag, crc result, frame kind and purge flag.
//   cfg_we_i/cfg_wdata_i write the purge threshold; write it only while idle, the block does not enforce this.
// path: a byte accepted into the input register is processed by the core from there, and
//   its word is captured in the output register once that register is free or emptying.
// throughput: one byte per cycle while the output words are taken; the crc byte update, escape decode and counter
//   compare all sit in the single stage between input and output registers.
// stalls: while the output word is not taken the input register holds, so the
//   input accepts at most one more byte and then drops in_ready_o.
// reset: both registers empty, no escape pending, position and crc cleared, the
//   next frame is the epoch request, good-frame count 0, threshold 60.
module escaped_frame_receiver_crc16 import efr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic [3:0] byte_index_o,
  output logic       frame_end_o,
  output logic       crc_ok_o,
  output logic       frame_kind_o,
  output logic       purge_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  `include "escaped_frame_receiver_crc16_defines.svh"

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  efr_result_t out_q;
  logic [7:0]  threshold_q;

  logic        advance;
  logic        res_valid;
  efr_result_t res;

  // the held byte moves on whenever the output register is free or emptying
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= PURGE_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  efr_frame_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .threshold_i (threshold_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_byte_o  = out_q.data_byte;
  assign byte_index_o = out_q.byte_index;
  assign frame_end_o  = out_q.frame_end;
  assign crc_ok_o     = out_q.crc_ok;
  assign frame_kind_o = out_q.frame_kind;
  assign purge_o      = out_q.purge;

  `EFR_ASSERT_NOW(a_end_at_last, out_valid_o && frame_end_o, byte_index_o == LAST_POS, "frame end away from last index")
  `EFR_ASSERT_NOW(a_purge_good_data, out_valid_o && purge_o, frame_end_o && crc_ok_o && frame_kind_o == KIND_DATA, "purge without good data frame end")
  `EFR_ASSERT_NOW(a_stall_only_blocked, !in_ready_o, in_valid_q && out_valid_o && !out_ready_i, "input stalled while pipeline can move")
  `EFR_ASSERT_NEXT(a_kind_sticky, out_valid_o && frame_kind_o == KIND_DATA && out_ready_i, !out_valid_o || frame_kind_o == KIND_DATA, "frame kind returned to epoch request")

endmodule
